/* rtl/rhfe_pkg.sv */
// ----------------------------------------------------------------------------
// rhfe_pkg
// Shared types and constants for the rectifying homography pipeline.
// ----------------------------------------------------------------------------
package rhfe_pkg;

  // Register indexes on the configuration channel
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [15:0] RESET_WIDTH  = 16'd640;
  localparam logic [15:0] RESET_HEIGHT = 16'd480;

  // Status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_DEGENERATE = 2'd1;
  localparam logic [1:0] STATUS_SATURATED  = 2'd2;

  // Fixed datapath widths
  localparam int COORD_W = 48;   // input coordinate, Q32.16
  localparam int DIFF_W  = 49;   // coordinate minus image center
  localparam int MAG_W   = 48;   // magnitude of the offset
  localparam int SQ1_W   = 96;   // square of one magnitude
  localparam int R2_W    = 97;   // sum of squares
  localparam int SQ_IN_W = 126;  // normalized radicand
  localparam int ROOT_W  = 63;   // square root of the radicand
  localparam int BL_W    = 7;    // bit length of the sum of squares
  localparam int M_W     = 6;    // normalization exponent

  typedef struct packed {
    logic signed [COORD_W-1:0] epipole_x;
    logic signed [COORD_W-1:0] epipole_y;
  } in_t;

  typedef struct packed {
    logic signed [63:0] h_r0_c0;
    logic signed [63:0] h_r0_c1;
    logic signed [63:0] h_r0_c2;
    logic signed [63:0] h_r1_c0;
    logic signed [63:0] h_r1_c1;
    logic signed [63:0] h_r1_c2;
    logic signed [63:0] h_r2_c0;
    logic signed [63:0] h_r2_c1;
    logic signed [63:0] h_r2_c2;
    logic        [1:0]  status;
  } out_t;

endpackage

/* rtl/rhfe_sqrt.sv */
// ----------------------------------------------------------------------------
// rhfe_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rhfe_sqrt #(
  parameter int RW = 63
) (
  input  logic            clk,
  input  logic [2*RW-1:0] x,
  output logic [RW-1:0]   root
);

  logic [2*RW-1:0] xs_q   [0:RW];
  logic [RW:0]     rem_q  [0:RW];
  logic [RW-1:0]   root_q [0:RW];

  always_ff @(posedge clk) begin
    xs_q[0]   <= x;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [RW+2:0] cur;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          fits;

    // bring down the next two radicand bits, try root*4+1
    assign cur   = {rem_q[i], xs_q[i][2*RW-1 -: 2]};
    assign trial = {1'b0, root_q[i], 2'b01};
    assign fits  = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      xs_q[i+1]   <= {xs_q[i][2*RW-3:0], 2'b00};
      rem_q[i+1]  <= fits ? diff[RW:0] : cur[RW:0];
      root_q[i+1] <= {root_q[i][RW-2:0], fits};
    end
  end

  assign root = root_q[RW];

endmodule

/* rtl/rhfe_div.sv */
// ----------------------------------------------------------------------------
// rhfe_div
// Pipelined restoring divider with round-half-up, one quotient bit per stage.
// The upper DW bits of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module rhfe_div #(
  parameter int QW = 49,
  parameter int DW = 63
) (
  input  logic             clk,
  input  logic [QW+DW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  logic [DW-1:0] rem_q [0:QW];
  logic [QW-1:0] lo_q  [0:QW];
  logic [QW-1:0] quo_q [0:QW];
  logic [DW-1:0] den_q [0:QW];
  logic          half_up;

  always_ff @(posedge clk) begin
    rem_q[0] <= num[QW+DW-1:QW];
    lo_q[0]  <= num[QW-1:0];
    quo_q[0] <= '0;
    den_q[0] <= den;
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        fits;

    assign trial = {rem_q[i], lo_q[i][QW-1]};
    assign fits  = trial >= {1'b0, den_q[i]};
    assign diff  = trial - {1'b0, den_q[i]};

    always_ff @(posedge clk) begin
      rem_q[i+1] <= fits ? diff[DW-1:0] : trial[DW-1:0];
      lo_q[i+1]  <= {lo_q[i][QW-2:0], 1'b0};
      quo_q[i+1] <= {quo_q[i][QW-2:0], fits};
      den_q[i+1] <= den_q[i];
    end
  end

  // round up when twice the remainder reaches the divisor
  assign half_up = {rem_q[QW], 1'b0} >= {1'b0, den_q[QW]};

  always_ff @(posedge clk) begin
    quo <= quo_q[QW] + QW'(half_up);
  end

endmodule

/* rtl/rectifying_homography_from_epipole.sv */
// ----------------------------------------------------------------------------
// rectifying_homography_from_epipole
// Rectifying homography that sends an epipole to infinity on the x axis.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request (epipole_x, epipole_y, Q32.16) and pulse
//   start. A request is taken at each clock edge with start high and busy
//   low. busy never rises: the pipeline takes one request every cycle.
//   Result channel: done is high for exactly one cycle with the nine
//   matrix entries (Q.FRAC_BITS_OUT) and status on result. Results leave in
//   request order. The receiver cannot stall; capture results when done.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write
//   image_width (index 0) or image_height (index 1). cfg_ready is always
//   high. Write only while no request is in flight.
//   The pipeline runs through the 63-stage square root and the dividers;
//   throughput one request per cycle.
//   Reset (rst, synchronous) drops every request in flight and restores
//   640 x 480.
// ----------------------------------------------------------------------------
module rectifying_homography_from_epipole
  import rhfe_pkg::*;
#(
  parameter int FRAC_BITS_OUT = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  request,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 done,
  output out_t                 result
);

  localparam int F      = FRAC_BITS_OUT;
  localparam int QW     = F + 17;          // quotient bits of every divider
  localparam int SW     = QW + 1;          // signed c, s, p, q
  localparam int PW_W   = SW + 17;         // product with a 16-bit size
  localparam int UW     = PW_W + 1;
  localparam int VW     = UW + 2;
  localparam int WV_W   = VW + 17;
  localparam int NW     = F + 56;          // matrix numerators, times 4
  localparam int CS_NW  = QW + ROOT_W;
  localparam int PQ_NW  = QW + R2_W;
  localparam int SQ_LAT = ROOT_W + 1;
  localparam int DV_LAT = QW + 2;
  localparam int LATENCY = F + 96;
  localparam logic signed [NW-1:0] ONE = NW'(1) << F;
  localparam logic signed [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SAT_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] ONE_OUT = 64'sd1 <<< F;

  // Front stages: offset, magnitude, squares, bit length
  typedef struct packed {
    logic                     vld;
    logic                     degen;
    logic                     negx;
    logic                     negy;
    logic                     sneg;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [MAG_W-1:0]         ax;
    logic [MAG_W-1:0]         ay;
    logic [63:0]              xll;
    logic [63:0]              yll;
    logic [47:0]              xlh;
    logic [47:0]              ylh;
    logic [31:0]              xhh;
    logic [31:0]              yhh;
    logic [SQ1_W-1:0]         rx2;
    logic [SQ1_W-1:0]         ry2;
    logic [R2_W-1:0]          r2;
    logic [M_W-1:0]           m;
  } fr_t;

  typedef struct packed {
    logic vld;
    logic degen;
    logic negx;
    logic negy;
    logic sneg;
  } fl_t;

  // Back stages: signed terms, products, numerators
  typedef struct packed {
    logic                   vld;
    logic                   degen;
    logic signed [SW-1:0]   c;
    logic signed [SW-1:0]   s;
    logic signed [SW-1:0]   p;
    logic signed [SW-1:0]   q;
    logic signed [PW_W-1:0] pw;
    logic signed [PW_W-1:0] qw;
    logic signed [PW_W-1:0] ph;
    logic signed [PW_W-1:0] qh;
    logic signed [PW_W-1:0] sw;
    logic signed [PW_W-1:0] sh;
    logic signed [UW-1:0]   u;
    logic signed [VW-1:0]   v;
    logic signed [WV_W-1:0] wv;
    logic signed [WV_W-1:0] hv;
    logic [8:0][NW-1:0]     n;
  } mx_t;

  logic [15:0] img_w;
  logic [15:0] img_h;

  fr_t f1, f2, f3, f4, f5, f6;
  fr_t f1_next, f2_next, f3_next, f4_next, f5_next, f6_next;
  fr_t tag_q [0:SQ_LAT-1];
  fr_t tag_end;
  fl_t fl_q  [0:DV_LAT-1];
  fl_t fl_end;
  mx_t ma, mb, mc, md, me, mf;
  mx_t ma_next, mb_next, mc_next, md_next, me_next, mf_next;

  logic [SQ_IN_W-1:0] sq_x;
  logic [ROOT_W-1:0]  root;
  logic [CS_NW-1:0]   num_c, num_s;
  logic [PQ_NW-1:0]   num_p, num_q;
  logic [QW-1:0]      c_mag, s_mag, p_mag, q_mag;
  logic [BL_W-1:0]    bl;
  out_t               result_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= RESET_WIDTH;
      img_h <= RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  img_w <= cfg_data;
        REG_IMAGE_HEIGHT: img_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: move the epipole so the image center is the origin
  always_comb begin
    f1_next     = '0;
    f1_next.vld = start && !busy;
    f1_next.dx  = {request.epipole_x[COORD_W-1], request.epipole_x}
                - {{(DIFF_W-31){1'b0}}, img_w, 15'b0};
    f1_next.dy  = {request.epipole_y[COORD_W-1], request.epipole_y}
                - {{(DIFF_W-31){1'b0}}, img_h, 15'b0};
  end

  // Stage 2: magnitudes and signs; s flips when the offsets differ in sign
  always_comb begin
    f2_next      = f1;
    f2_next.negx = f1.dx[DIFF_W-1];
    f2_next.negy = f1.dy[DIFF_W-1];
    f2_next.ax   = f1.dx[DIFF_W-1] ? MAG_W'(-f1.dx) : MAG_W'(f1.dx);
    f2_next.ay   = f1.dy[DIFF_W-1] ? MAG_W'(-f1.dy) : MAG_W'(f1.dy);
    f2_next.sneg = (f1.dy != '0) && (f1.dx[DIFF_W-1] != f1.dy[DIFF_W-1]);
  end

  // Stage 3: partial products of the squares (low 32-bit and high 16-bit parts)
  always_comb begin
    f3_next       = f2;
    f3_next.degen = (f2.ax == '0) && (f2.ay == '0);
    f3_next.xll   = f2.ax[31:0] * f2.ax[31:0];
    f3_next.xlh   = f2.ax[31:0] * f2.ax[47:32];
    f3_next.xhh   = f2.ax[47:32] * f2.ax[47:32];
    f3_next.yll   = f2.ay[31:0] * f2.ay[31:0];
    f3_next.ylh   = f2.ay[31:0] * f2.ay[47:32];
    f3_next.yhh   = f2.ay[47:32] * f2.ay[47:32];
  end

  // Stage 4: assemble each square
  always_comb begin
    f4_next     = f3;
    f4_next.rx2 = {32'b0, f3.xll} + {15'b0, f3.xlh, 33'b0} + {f3.xhh, 64'b0};
    f4_next.ry2 = {32'b0, f3.yll} + {15'b0, f3.ylh, 33'b0} + {f3.yhh, 64'b0};
  end

  // Stage 5: squared distance
  always_comb begin
    f5_next    = f4;
    f5_next.r2 = {1'b0, f4.rx2} + {1'b0, f4.ry2};
  end

  // Stage 6: normalization exponent from the bit length
  always_comb begin
    bl = '0;
    for (int i = 0; i < R2_W; i++) begin
      if (f5.r2[i]) bl = BL_W'(i + 1);
    end
    f6_next   = f5;
    f6_next.m = M_W'((BL_W'(SQ_IN_W) - bl) >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1 <= '0;
      f2 <= '0;
      f3 <= '0;
      f4 <= '0;
      f5 <= '0;
      f6 <= '0;
    end else begin
      f1 <= f1_next;
      f2 <= f2_next;
      f3 <= f3_next;
      f4 <= f4_next;
      f5 <= f5_next;
      f6 <= f6_next;
    end
  end

  // Square root of the normalized radicand; hold the item alongside
  assign sq_x = {{(SQ_IN_W-R2_W){1'b0}}, f6.r2} << {f6.m, 1'b0};

  rhfe_sqrt #(
    .RW (ROOT_W)
  ) u_sqrt (
    .clk  (clk),
    .x    (sq_x),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQ_LAT; i++) tag_q[i] <= '0;
    end else begin
      tag_q[0] <= f6;
      for (int i = 1; i < SQ_LAT; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  assign tag_end = tag_q[SQ_LAT-1];

  // Cosine and sine share the root as divisor; p and q divide by r^2
  assign num_c = {{(CS_NW-MAG_W){1'b0}}, tag_end.ax} << (F + int'(tag_end.m));
  assign num_s = {{(CS_NW-MAG_W){1'b0}}, tag_end.ay} << (F + int'(tag_end.m));
  assign num_p = {{(PQ_NW-MAG_W){1'b0}}, tag_end.ax} << (16 + F);
  assign num_q = {{(PQ_NW-MAG_W){1'b0}}, tag_end.ay} << (16 + F);

  rhfe_div #(.QW(QW), .DW(ROOT_W)) u_div_c (
    .clk (clk), .num (num_c), .den (root), .quo (c_mag)
  );
  rhfe_div #(.QW(QW), .DW(ROOT_W)) u_div_s (
    .clk (clk), .num (num_s), .den (root), .quo (s_mag)
  );
  rhfe_div #(.QW(QW), .DW(R2_W)) u_div_p (
    .clk (clk), .num (num_p), .den (tag_end.r2), .quo (p_mag)
  );
  rhfe_div #(.QW(QW), .DW(R2_W)) u_div_q (
    .clk (clk), .num (num_q), .den (tag_end.r2), .quo (q_mag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DV_LAT; i++) fl_q[i] <= '0;
    end else begin
      fl_q[0] <= '{vld: tag_end.vld, degen: tag_end.degen, negx: tag_end.negx,
                   negy: tag_end.negy, sneg: tag_end.sneg};
      for (int i = 1; i < DV_LAT; i++) fl_q[i] <= fl_q[i-1];
    end
  end

  assign fl_end = fl_q[DV_LAT-1];

  // Stage A: apply signs
  always_comb begin
    ma_next       = '0;
    ma_next.vld   = fl_end.vld;
    ma_next.degen = fl_end.degen;
    ma_next.c     = $signed({1'b0, c_mag});
    ma_next.s     = fl_end.sneg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    ma_next.p     = fl_end.negx ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
    ma_next.q     = fl_end.negy ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  end

  // Stage B: products with the image size
  always_comb begin
    mb_next    = ma;
    mb_next.pw = ma.p * $signed({1'b0, img_w});
    mb_next.qw = ma.q * $signed({1'b0, img_w});
    mb_next.ph = ma.p * $signed({1'b0, img_h});
    mb_next.qh = ma.q * $signed({1'b0, img_h});
    mb_next.sw = ma.s * $signed({1'b0, img_w});
    mb_next.sh = ma.s * $signed({1'b0, img_h});
  end

  // Stage C: u = 2*(p cx + q cy) and the entries that need no second product
  always_comb begin
    mc_next      = mb;
    mc_next.u    = UW'(mb.pw) + UW'(mb.qh);
    mc_next.n[0] = (NW'(mb.c) <<< 2) - (NW'(mb.pw) <<< 1);
    mc_next.n[1] = (NW'(mb.s) <<< 2) - (NW'(mb.qw) <<< 1);
    mc_next.n[3] = -(NW'(mb.s) <<< 2) - (NW'(mb.ph) <<< 1);
    mc_next.n[4] = (NW'(mb.c) <<< 2) - (NW'(mb.qh) <<< 1);
    mc_next.n[6] = -(NW'(mb.p) <<< 2);
    mc_next.n[7] = -(NW'(mb.q) <<< 2);
  end

  // Stage D: v = 2 + u - 2c, and k four times over
  always_comb begin
    md_next      = mc;
    md_next.v    = (VW'(ONE) <<< 1) + VW'(mc.u) - (VW'(mc.c) <<< 1);
    md_next.n[8] = (ONE <<< 2) + (NW'(mc.u) <<< 1);
  end

  // Stage E: scale v by the image size
  always_comb begin
    me_next    = md;
    me_next.wv = md.v * $signed({1'b0, img_w});
    me_next.hv = md.v * $signed({1'b0, img_h});
  end

  // Stage F: last-column entries of the first two rows
  always_comb begin
    mf_next      = me;
    mf_next.n[2] = NW'(me.wv) - (NW'(me.sh) <<< 1);
    mf_next.n[5] = NW'(me.hv) + (NW'(me.sw) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ma <= '0;
      mb <= '0;
      mc <= '0;
      md <= '0;
      me <= '0;
      mf <= '0;
    end else begin
      ma <= ma_next;
      mb <= mb_next;
      mc <= mc_next;
      md <= md_next;
      me <= me_next;
      mf <= mf_next;
    end
  end

  // Divide by four with rounding, clamp to 64 bits; bit 64 flags a clamp
  function automatic logic [64:0] round_sat(input logic [NW-1:0] n);
    logic [NW-1:0] t;
    logic          fits;
    t    = n + NW'(2);
    fits = (t[NW-1:65] == '0) || (t[NW-1:65] == '1);
    if (fits) round_sat = {1'b0, t[65:2]};
    else      round_sat = {1'b1, t[NW-1] ? SAT_MIN : SAT_MAX};
  endfunction

  always_comb begin
    logic [8:0][64:0] e;
    logic             any_sat;
    any_sat = 1'b0;
    for (int i = 0; i < 9; i++) begin
      e[i]    = round_sat(mf.n[i]);
      any_sat = any_sat | e[i][64];
    end
    if (mf.degen) begin
      result_next         = '0;
      result_next.h_r0_c0 = ONE_OUT;
      result_next.h_r1_c1 = ONE_OUT;
      result_next.h_r2_c2 = ONE_OUT;
      result_next.status  = STATUS_DEGENERATE;
    end else begin
      result_next.h_r0_c0 = e[0][63:0];
      result_next.h_r0_c1 = e[1][63:0];
      result_next.h_r0_c2 = e[2][63:0];
      result_next.h_r1_c0 = e[3][63:0];
      result_next.h_r1_c1 = e[4][63:0];
      result_next.h_r1_c2 = e[5][63:0];
      result_next.h_r2_c0 = e[6][63:0];
      result_next.h_r2_c1 = e[7][63:0];
      result_next.h_r2_c2 = e[8][63:0];
      result_next.status  = any_sat ? STATUS_SATURATED : STATUS_OK;
    end
  end

  // Output register: strobe done for one cycle per result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mf.vld;
    end
    result <= result_next;
  end

endmodule

/* rtl/rhfe_check.sv */
// ----------------------------------------------------------------------------
// rhfe_check
// Port-level checks for the rectifying homography pipeline.
// ----------------------------------------------------------------------------
module rhfe_check
  import rhfe_pkg::*;
#(
  parameter int LAT           = 128,
  parameter int FRAC_BITS_OUT = 32
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input out_t result
);

  localparam logic signed [63:0] ONE_OUT = 64'sd1 <<< FRAC_BITS_OUT;

  // every request comes back after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not complete after the pipeline latency");

  // no result without a request the latency before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  // a centered epipole yields the identity
  a_degenerate: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_DEGENERATE) |->
      (result.h_r0_c0 == ONE_OUT && result.h_r1_c1 == ONE_OUT &&
       result.h_r2_c2 == ONE_OUT && result.h_r0_c1 == 64'sd0 &&
       result.h_r2_c0 == 64'sd0 && result.h_r1_c2 == 64'sd0))
    else $error("degenerate result is not the identity");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == STATUS_OK || result.status == STATUS_DEGENERATE ||
              result.status == STATUS_SATURATED))
    else $error("status code out of range");

endmodule

bind rectifying_homography_from_epipole rhfe_check #(
  .LAT           (LATENCY),
  .FRAC_BITS_OUT (FRAC_BITS_OUT)
) u_rhfe_check (.*);
